// ===== hw/rtl/sfomd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the serial frame to omni motor drive block.
// No dependencies; the duty unit, the top level and the bench import this package.
package sfomd_pkg;

  localparam int unsigned FRAME_KEPT = 7;

  localparam logic [7:0]  END_BYTE   = 8'h80;
  localparam logic [6:0]  SUM_MASK   = 7'h7f;
  localparam logic [7:0]  SPEED_OFFS = 8'd255;
  localparam logic [7:0]  DIV_CONST  = 8'd255;
  localparam logic [15:0] DUTY_MAX   = 16'hffff;

  // configuration register indexes and reset values
  localparam logic [1:0]  CFG_PWM_PERIOD    = 2'd0;
  localparam logic [1:0]  CFG_ROTATION_GAIN = 2'd1;
  localparam logic [1:0]  CFG_BRAKE_BELOW   = 2'd2;
  localparam logic [15:0] PWM_PERIOD_RST    = 16'd1473;
  localparam logic [2:0]  ROTATION_GAIN_RST = 3'd1;
  localparam logic [7:0]  BRAKE_BELOW_RST   = 8'd50;

  localparam logic [1:0]  LAST_WHEEL = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  motor_index;
    logic        forward_pin;
    logic        reverse_pin;
    logic [15:0] duty;
    logic        status_led;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MIX,
    ST_MUL,
    ST_WAIT,
    ST_EMIT
  } sfomd_state_t;

  typedef enum logic [1:0] {
    DU_IDLE,
    DU_DIV,
    DU_DONE
  } du_state_t;

endpackage

// ===== hw/rtl/sfomd_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interface used for the byte input and command output.
// Payload type is supplied per instance; no other dependencies.
interface sfomd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sfomd_duty.sv =====
`timescale 1ns / 1ps
// Duty unit: one multiply (period * magnitude), then an iterative divide by 255
// using digit folding, then saturation to 16 bits. Depends on sfomd_pkg.
module sfomd_duty (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] period,
  input  logic [12:0] mag,
  output logic        done,
  output logic [15:0] duty
);
  import sfomd_pkg::*;

  du_state_t   state_r, state_nxt;
  logic [28:0] rem_r, rem_nxt;
  logic [20:0] quo_r, quo_nxt;
  logic [20:0] fold;
  logic        rem_small;

  // invariant: product = 255*quo + rem; each fold keeps it and shrinks rem
  assign fold      = rem_r[28:8];
  assign rem_small = (fold == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DU_IDLE: if (start) state_nxt = DU_DIV;
      DU_DIV:  if (rem_small) state_nxt = DU_DONE;
      DU_DONE: state_nxt = DU_IDLE;
      default: state_nxt = DU_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    case (state_r)
      DU_IDLE: begin
        rem_nxt = {13'd0, period} * {16'd0, mag};
        quo_nxt = '0;
      end
      DU_DIV: begin
        if (rem_small) begin
          if (rem_r[7:0] == DIV_CONST) quo_nxt = quo_r + 21'd1;
        end else begin
          quo_nxt = quo_r + fold;
          rem_nxt = {21'd0, rem_r[7:0]} + {8'd0, fold};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = (state_r == DU_DONE);
  assign duty = (quo_r[20:16] != '0) ? DUTY_MAX : quo_r[15:0];

endmodule

// ===== hw/rtl/serial_frame_to_omni_motor_drive.sv =====
`timescale 1ns / 1ps
// Top level: serial frame decoder and four-wheel omni motor command generator.
// Depends on sfomd_pkg, sfomd_stream_if and sfomd_duty.
//
// Usage:
//   in_rx   : one word per received serial byte (rx_byte). Each word lands in
//             a frame slot; the slot wraps after WRAP_SLOTS words or after an
//             end byte 0x80.
//   out_cmd : four command words per good frame, wheels 0..3, last set on
//             wheel 3. A frame is good when the 7-bit sum of slots 0..5
//             equals slot 6 at the end byte.
//   cfg_*   : write-only register port (0 pwm_period, 1 rotation_gain,
//             2 brake_below); the user must write it while the block is idle (not enforced).
// Sequence: an ordinary byte is taken while idle and in_rx.ready stays high. An
//   end byte adds a checksum state. A good frame then runs each wheel through
//   mix, multiply, the fold steps and a done state in sfomd_duty, plus emit;
//   in_rx.ready returns once the command for wheel 3 has been emitted.
// Stall: a command waits in the output register; the sequencer holds before
//   loading the next one and in_rx.ready stays low.
// Reset (synchronous, rst_n low): slots, position and LED cleared, registers
//   back to 1473 / 1 / 50, no command pending.
module serial_frame_to_omni_motor_drive #(
  parameter int unsigned WRAP_SLOTS = 33
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sfomd_stream_if.sink           in_rx,
  sfomd_stream_if.source         out_cmd,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import sfomd_pkg::*;

  // configuration
  logic [15:0] period_r;
  logic [2:0]  gain_r;
  logic [7:0]  brake_r;

  // frame state
  logic [7:0]  frame_r [FRAME_KEPT];
  logic [5:0]  pos_r;
  logic [6:0]  pos_inc;
  logic        led_r;

  // sequencer
  sfomd_state_t state_r, state_nxt;
  logic [1:0]   wheel_r;
  logic signed [13:0] turn_r;
  logic [12:0]  mag_r;
  logic         neg_r;
  logic         brake_flag_r;
  logic [15:0]  duty_r;

  // output register
  logic         out_valid_r;
  out_word_t    out_word_r;

  // control strobes
  logic accept, check_ok, do_mix, du_start, du_done, emit, out_free;
  logic [15:0] du_duty;

  // checksum and decode
  logic [9:0]  sum6;
  logic signed [10:0] vx, vy, rot, base;
  logic signed [14:0] turn_prod;
  logic signed [13:0] vel;
  logic [13:0] vel_abs;

  assign sum6 = 10'(frame_r[0]) + 10'(frame_r[1]) + 10'(frame_r[2])
              + 10'(frame_r[3]) + 10'(frame_r[4]) + 10'(frame_r[5]);
  assign check_ok = (frame_r[6] == {1'b0, sum6[6:0] & SUM_MASK});

  // speed = 4*b - 255
  assign vx  = $signed({1'b0, frame_r[2], 2'b00}) - $signed({3'b000, SPEED_OFFS});
  assign vy  = $signed({1'b0, frame_r[3], 2'b00}) - $signed({3'b000, SPEED_OFFS});
  assign rot = $signed({1'b0, frame_r[4], 2'b00}) - $signed({3'b000, SPEED_OFFS});
  assign turn_prod = $signed({1'b0, gain_r}) * rot;

  always_comb begin
    case (wheel_r)
      2'd0:    base = vx;
      2'd1:    base = vy;
      2'd2:    base = -vx;
      default: base = -vy;
    endcase
  end

  assign vel     = {{3{base[10]}}, base} + turn_r;
  assign vel_abs = vel[13] ? 14'(-vel) : 14'(vel);

  assign pos_inc  = {1'b0, pos_r} + 7'd1;
  assign out_free = !out_valid_r || out_cmd.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_rx.data.rx_byte == END_BYTE) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = check_ok ? ST_MIX : ST_IDLE;
      ST_MIX:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WAIT;
      ST_WAIT:  if (du_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = (wheel_r == LAST_WHEEL) ? ST_IDLE : ST_MIX;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_rx.ready = 1'b0;
    do_mix      = 1'b0;
    du_start    = 1'b0;
    emit        = 1'b0;
    case (state_r)
      ST_IDLE: in_rx.ready = 1'b1;
      ST_MIX:  do_mix      = 1'b1;
      ST_MUL:  du_start    = 1'b1;
      ST_EMIT: emit        = out_free;
      default: ;
    endcase
  end

  assign accept = in_rx.valid && in_rx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      period_r    <= PWM_PERIOD_RST;
      gain_r      <= ROTATION_GAIN_RST;
      brake_r     <= BRAKE_BELOW_RST;
      pos_r       <= '0;
      led_r       <= 1'b0;
      wheel_r     <= '0;
      for (int i = 0; i < FRAME_KEPT; i++) frame_r[i] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_PWM_PERIOD:    period_r <= cfg_data;
          CFG_ROTATION_GAIN: gain_r   <= cfg_data[2:0];
          CFG_BRAKE_BELOW:   brake_r  <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (pos_r < 6'(FRAME_KEPT)) frame_r[pos_r[2:0]] <= in_rx.data.rx_byte;
        if (in_rx.data.rx_byte == END_BYTE || pos_inc >= 7'(WRAP_SLOTS)) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_inc[5:0];
        end
      end

      if (state_r == ST_CHECK && check_ok) begin
        led_r   <= !led_r;
        wheel_r <= '0;
      end else if (emit) begin
        wheel_r <= wheel_r + 2'd1;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_cmd.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) turn_r <= turn_prod[13:0];
    if (do_mix) begin
      mag_r        <= vel_abs[12:0];
      neg_r        <= vel[13];
      brake_flag_r <= (vel_abs < {6'd0, brake_r});
    end
    if (du_done) duty_r <= du_duty;
    if (emit) begin
      out_word_r.motor_index <= wheel_r;
      out_word_r.forward_pin <= brake_flag_r || !neg_r;
      out_word_r.reverse_pin <= brake_flag_r || neg_r;
      out_word_r.duty        <= duty_r;
      out_word_r.status_led  <= led_r;
      out_word_r.last        <= (wheel_r == LAST_WHEEL);
    end
  end

  sfomd_duty u_duty (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (du_start),
    .period (period_r),
    .mag    (mag_r),
    .done   (du_done),
    .duty   (du_duty)
  );

  assign out_cmd.valid = out_valid_r;
  assign out_cmd.data  = out_word_r;

endmodule

// ===== test/serial_frame_to_omni_motor_drive_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for serial_frame_to_omni_motor_drive: feeds serial bytes as
// frames, broken frames and noise, predicts every wheel command and checks it in order.
// Depends on sfomd_pkg, sfomd_stream_if and the RTL top level.
module serial_frame_to_omni_motor_drive_tb;
  import sfomd_pkg::*;

  localparam int unsigned WRAP_SLOTS   = 33;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;  // no register behind this index
  localparam int unsigned DRAIN_CYCLES = 80;    // margin for the block to finish a frame's four wheels
  localparam int unsigned HOLD_CYCLES  = 400;   // long out_cmd hold-off, fills the block

  // Expected-command store plus a private copy of the frame state and registers.
  class motor_cmd_board;
    out_word_t   queued_cmds[$];
    logic [7:0]  slots[FRAME_KEPT];
    int unsigned pos;
    logic        led;
    logic [15:0] period;
    logic [2:0]  gain;
    logic [7:0]  brake;
    int unsigned errors;

    function new();
      foreach (slots[i]) slots[i] = 8'd0;
      pos    = 0;
      led    = 1'b0;
      period = PWM_PERIOD_RST;
      gain   = ROTATION_GAIN_RST;
      brake  = BRAKE_BELOW_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_PWM_PERIOD:    period = data;
        CFG_ROTATION_GAIN: gain   = data[2:0];
        CFG_BRAKE_BELOW:   brake  = data[7:0];
        default: ;
      endcase
    endfunction

    function int speed(logic [7:0] b);
      return 4 * int'(b) - 255;
    endfunction

    function out_word_t wheel_cmd(logic [1:0] idx, int v);
      out_word_t       w;
      longint unsigned mag;
      longint unsigned d;
      mag = (v < 0) ? -v : v;
      d   = (longint'(period) * mag) / 255;
      w.motor_index = idx;
      w.forward_pin = (v >= 0);
      w.reverse_pin = (v < 0);
      if (mag < brake) begin
        w.forward_pin = 1'b1;
        w.reverse_pin = 1'b1;
      end
      w.duty       = (d > DUTY_MAX) ? DUTY_MAX : d[15:0];
      w.status_led = led;
      w.last       = (idx == LAST_WHEEL);
      return w;
    endfunction

    // One accepted input word: store, advance, and on a good end byte queue four commands.
    function void note_byte(logic [7:0] b);
      logic [6:0] sum7;
      int         vx, vy, turn;
      int         i;
      if (pos < FRAME_KEPT) slots[pos] = b;
      pos++;
      if (pos >= WRAP_SLOTS) pos = 0;
      if (b != END_BYTE) return;
      pos  = 0;
      sum7 = '0;
      for (i = 0; i < 6; i++) sum7 = sum7 + slots[i];
      if ({1'b0, sum7} != slots[6]) return;
      vx   = speed(slots[2]);
      vy   = speed(slots[3]);
      turn = int'(gain) * speed(slots[4]);
      led  = ~led;
      queued_cmds.push_back(wheel_cmd(2'd0, vx + turn));
      queued_cmds.push_back(wheel_cmd(2'd1, vy + turn));
      queued_cmds.push_back(wheel_cmd(2'd2, -vx + turn));
      queued_cmds.push_back(wheel_cmd(2'd3, -vy + turn));
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_cmd(out_word_t got);
      out_word_t want;
      if (queued_cmds.size() == 0) begin
        errors++;
        $display("%0t unexpected command: expected none, actual %h", $time, got);
        return;
      end
      want = queued_cmds.pop_front();
      if (got.motor_index !== want.motor_index)
        report("motor_index", want.motor_index, got.motor_index);
      if (got.forward_pin !== want.forward_pin)
        report("forward_pin", want.forward_pin, got.forward_pin);
      if (got.reverse_pin !== want.reverse_pin)
        report("reverse_pin", want.reverse_pin, got.reverse_pin);
      if (got.duty !== want.duty) report("duty", want.duty, got.duty);
      if (got.status_led !== want.status_led)
        report("status_led", want.status_led, got.status_led);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  sfomd_stream_if #(.payload_t(in_word_t))  rx_if ();
  sfomd_stream_if #(.payload_t(out_word_t)) cmd_if ();

  motor_cmd_board board;
  bit             quiet_tail;   // last phase: no gaps on either side
  bit             tx_calm;      // sender skips gaps for the current frame
  int unsigned    cmds_seen;
  int unsigned    bytes_sent;

  serial_frame_to_omni_motor_drive #(.WRAP_SLOTS(WRAP_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_rx     (rx_if),
    .out_cmd   (cmd_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses commands.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Every command word taken at a rising edge goes straight to the checker.
  always @(posedge clk) begin
    if (rst_n && cmd_if.valid && cmd_if.ready) begin
      board.check_cmd(cmd_if.data);
      cmds_seen++;
    end
  end

  // Command sink: random stall bursts, calm stretches, and one long hold-off once
  // traffic is flowing so the block backs up into in_rx.
  initial begin : cmd_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned calm_left;
    bit          calm;
    bit          held;
    stall_left   = 0;
    hold_left    = 0;
    calm_left    = 0;
    calm         = 1'b0;
    held         = 1'b0;
    cmd_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && cmds_seen >= 16) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(50, 200);
      end else begin
        calm_left--;
      end
      if (hold_left != 0) begin
        cmd_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        cmd_if.ready <= 1'b0;
        stall_left--;
      end else begin
        cmd_if.ready <= 1'b1;
        if (!quiet_tail && !calm && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Offer one byte; called and returns at a falling edge. valid stays high between
  // words and only drops for a gap or a drain.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet_tail && !tx_calm && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.data  <= in_word_t'(b);
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_but_end();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == END_BYTE);
    return b;
  endfunction

  // Speed bytes lean toward the ends of the range.
  function automatic logic [7:0] speed_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return any_but_end();
    endcase
  endfunction

  // Six payload bytes, check byte, pad bytes in the unkept slots, then the end byte.
  // spoil flips one low bit of the check byte, keeping it below the end byte.
  task automatic send_frame(input logic [7:0] f0, f1, f2, f3, f4, f5,
                            input int unsigned pad, input bit spoil);
    logic [6:0] sum7;
    logic [7:0] check;
    sum7  = f0 + f1 + f2 + f3 + f4 + f5;
    check = {1'b0, sum7};
    if (spoil) check = check ^ (8'd1 << $urandom_range(0, 6));
    send_byte(f0);
    send_byte(f1);
    send_byte(f2);
    send_byte(f3);
    send_byte(f4);
    send_byte(f5);
    send_byte(check);
    repeat (pad) send_byte(any_but_end());
    send_byte(END_BYTE);
  endtask

  task automatic send_good_frame(input int unsigned pad);
    send_frame(any_but_end(), any_but_end(), speed_byte(), speed_byte(), speed_byte(),
               any_but_end(), pad, 1'b0);
  endtask

  // Mostly well-formed frames; some spoiled, some noise, some runs through the wrap.
  task automatic random_phase(input int unsigned n_words);
    int unsigned first;
    int unsigned pad;
    int unsigned k;
    first = bytes_sent;
    while (bytes_sent - first < n_words) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      pad     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 15) == 0) pad = 25;  // end byte lands in the last slot
      case ($urandom_range(0, 9))
        0: send_frame(any_but_end(), any_but_end(), speed_byte(), speed_byte(),
                      speed_byte(), any_but_end(), pad, 1'b1);
        1: begin
          // raw noise, closed half the time by a lone end byte to resync
          k = $urandom_range(1, 10);
          repeat (k) send_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1) send_byte(END_BYTE);
        end
        2: begin
          // no end byte until the position wraps back to slot 0, then a frame
          k = WRAP_SLOTS - board.pos;
          repeat (k) send_byte(any_but_end());
          send_good_frame(0);
        end
        default: send_good_frame(pad);
      endcase
    end
  endtask

  // Idle the input and wait out all pending commands plus the block's own work.
  task automatic drain();
    rx_if.valid <= 1'b0;
    while (board.queued_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Unused upper data bits carry garbage; the dead index gets a write too.
  task automatic load_regs(input logic [15:0] period, input logic [2:0] gain,
                           input logic [7:0] brake);
    write_reg(CFG_ROTATION_GAIN, {13'($urandom), gain});
    write_reg(CFG_PWM_PERIOD, period);
    write_reg(CFG_BRAKE_BELOW, {8'($urandom), brake});
    write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  initial begin : stimulus
    board       = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_PWM_PERIOD;
    cfg_data    = '0;
    rx_if.valid = 1'b0;
    rx_if.data  = '0;
    quiet_tail  = 1'b0;
    tx_calm     = 1'b0;
    cmds_seen   = 0;
    bytes_sent  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values. Full-scale frame, then the same with a bad check byte,
    // then an end byte that lands early in slot 3 and is stored there.
    send_frame(8'h00, 8'hff, 8'hff, 8'h00, 8'h7f, 8'h01, 0, 1'b0);
    send_frame(8'h00, 8'hff, 8'hff, 8'h00, 8'h7f, 8'h01, 0, 1'b1);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(END_BYTE);
    drain();

    // Gain 3: wheel 0 sums to exactly zero (-255 + 3*85) and must drive forward
    // with braking off; wheel 2 reaches 510 and saturates the duty at full period.
    load_regs(16'hffff, 3'd3, 8'd0);
    send_frame(8'h12, 8'h34, 8'h00, 8'h40, 8'h55, 8'h7e, 0, 1'b0);
    drain();

    // Random traffic under several register settings, extremes included.
    load_regs(PWM_PERIOD_RST, ROTATION_GAIN_RST, BRAKE_BELOW_RST);
    random_phase(64);
    drain();
    load_regs(16'd0, 3'd0, 8'd0);
    random_phase(48);
    drain();
    load_regs(16'hffff, 3'd7, 8'hff);
    random_phase(48);
    drain();
    load_regs(16'($urandom), 3'($urandom_range(0, 7)), 8'($urandom));
    random_phase(64);
    drain();
    load_regs(16'd1000, 3'd4, 8'd100);
    quiet_tail = 1'b1;
    random_phase(96);
    drain();

    if (board.errors == 0 && board.queued_cmds.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sfomd_pkg.sv
hw/rtl/sfomd_stream_if.sv
hw/rtl/sfomd_duty.sv
hw/rtl/serial_frame_to_omni_motor_drive.sv
test/serial_frame_to_omni_motor_drive_tb.sv
